// ===== sv/epl_pkg.sv =====
// ----------------------------------------------------------------------------
// epl_pkg - shared types, constants and microcode for the PI position loop
// Holds the datapath widths, register codes, control-word layout and the
// microprogram table that sequences one item through the shared datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package epl_pkg;

  // State width of position and integrator (16 .. 32)
  localparam int STATE_WIDTH = 16;

  // Error holds target (16 bits unsigned) minus a STATE_WIDTH position
  localparam int ERR_W  = STATE_WIDTH + 2;
  // Signed product of an ERR_W operand and a 9-bit zero-extended gain
  localparam int PROD_W = ERR_W + 9;
  // Drive accumulator: sum of two products
  localparam int DRV_W  = PROD_W + 1;

  localparam logic signed [ERR_W:0] INTEG_MAX =
    {{(ERR_W - STATE_WIDTH + 2){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
  localparam logic signed [ERR_W:0] INTEG_MIN = ~INTEG_MAX;

  // Configuration register indexes
  localparam logic [1:0] REG_SETPOINT_SCALE    = 2'd0;
  localparam logic [1:0] REG_GAIN_PROPORTIONAL = 2'd1;
  localparam logic [1:0] REG_GAIN_INTEGRAL     = 2'd2;

  localparam logic [7:0] RESET_SETPOINT_SCALE    = 8'd35;
  localparam logic [7:0] RESET_GAIN_PROPORTIONAL = 8'd1;
  localparam logic [7:0] RESET_GAIN_INTEGRAL     = 8'd0;

  localparam logic [7:0] DRIVE_LIMIT = 8'hff;

  // Microprogram addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_WAIT   = 3'd0;
  localparam logic [STEP_W-1:0] ST_POS    = 3'd1;
  localparam logic [STEP_W-1:0] ST_ERR    = 3'd2;
  localparam logic [STEP_W-1:0] ST_INTEG  = 3'd3;
  localparam logic [STEP_W-1:0] ST_PTERM  = 3'd4;
  localparam logic [STEP_W-1:0] ST_ITERM  = 3'd5;
  localparam logic [STEP_W-1:0] ST_EMIT   = 3'd6;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TARGET,
    MUL_PROP,
    MUL_INTEG
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_NO_INPUT,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    logic              pos_en;
    mul_sel_t          mul_sel;
    logic              err_en;
    logic              integ_en;
    acc_op_t           acc_op;
    logic              out_load;
    jcond_t            jcond;
    logic [STEP_W-1:0] jtarget;
    logic              last;
  } ctrl_word_t;

  localparam ctrl_word_t CW_NOP = '{
    pos_en: 1'b0, mul_sel: MUL_NONE, err_en: 1'b0, integ_en: 1'b0,
    acc_op: ACC_HOLD, out_load: 1'b0, jcond: JC_NONE, jtarget: ST_WAIT,
    last: 1'b0
  };

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = CW_NOP;
    unique case (step)
      ST_WAIT: begin
        cw.jcond   = JC_NO_INPUT;
        cw.jtarget = ST_WAIT;
      end
      ST_POS: begin
        cw.pos_en  = 1'b1;
        cw.mul_sel = MUL_TARGET;
      end
      ST_ERR: begin
        cw.err_en = 1'b1;
      end
      ST_INTEG: begin
        cw.integ_en = 1'b1;
        cw.mul_sel  = MUL_PROP;
      end
      ST_PTERM: begin
        cw.acc_op  = ACC_LOAD;
        cw.mul_sel = MUL_INTEG;
      end
      ST_ITERM: begin
        cw.acc_op = ACC_ADD;
      end
      ST_EMIT: begin
        cw.out_load = 1'b1;
        cw.jcond    = JC_OUT_BUSY;
        cw.jtarget  = ST_EMIT;
        cw.last     = 1'b1;
      end
      default: cw = CW_NOP;
    endcase
    return cw;
  endfunction

  function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
    logic [7:0] t;
    t = ((v >> 1) & 8'h55) | ((v << 1) & 8'haa);
    t = ((t >> 2) & 8'h33) | ((t << 2) & 8'hcc);
    t = ((t >> 4) & 8'h0f) | ((t << 4) & 8'hf0);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/epl_datapath.sv =====
// ----------------------------------------------------------------------------
// epl_datapath - shared-multiplier datapath of the PI position loop
// Input capture, position and integrator state, one multiplier and the
// drive accumulator, each stepped by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module epl_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire epl_pkg::ctrl_word_t  ctrl,
  input  wire logic                 take,
  input  wire logic [7:0]           setpoint_byte,
  input  wire logic [7:0]           encoder_high_raw,
  input  wire logic [7:0]           encoder_low_raw,
  input  wire logic [7:0]           setpoint_scale,
  input  wire logic [7:0]           gain_proportional,
  input  wire logic [7:0]           gain_integral,
  output logic [7:0]                mag,
  output logic                      rev
);

  localparam int SW = epl_pkg::STATE_WIDTH;
  localparam int EW = epl_pkg::ERR_W;
  localparam int PW = epl_pkg::PROD_W;
  localparam int DW = epl_pkg::DRV_W;

  logic [7:0]              setp;
  logic signed [15:0]      delta;
  logic signed [SW-1:0]    pos;
  logic signed [SW-1:0]    integ;
  logic signed [EW-1:0]    err;
  logic signed [PW-1:0]    prod;
  logic signed [DW-1:0]    acc;

  logic signed [EW-1:0]    mul_a;
  logic signed [8:0]       mul_b;
  logic signed [PW-1:0]    mul_p;
  logic signed [EW:0]      isum;
  logic signed [DW-1:0]    prod_x;
  logic signed [DW-1:0]    drv_abs;
  logic                    drv_pos;

  // Capture the item; bit-reverse the encoder bytes on the way in
  always_ff @(posedge clk) begin
    if (take) begin
      setp  <= setpoint_byte;
      delta <= {epl_pkg::bit_reverse8(encoder_high_raw),
                epl_pkg::bit_reverse8(encoder_low_raw)};
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      epl_pkg::MUL_TARGET: begin
        mul_a = {{(EW - 8){1'b0}}, setp};
        mul_b = {1'b0, setpoint_scale};
      end
      epl_pkg::MUL_PROP: begin
        mul_a = err;
        mul_b = {1'b0, gain_proportional};
      end
      epl_pkg::MUL_INTEG: begin
        mul_a = {{(EW - SW){integ[SW-1]}}, integ};
        mul_b = {1'b0, gain_integral};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign isum   = {{(EW + 1 - SW){integ[SW-1]}}, integ} + {err[EW-1], err};
  assign prod_x = {prod[PW-1], prod};

  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != epl_pkg::MUL_NONE) begin
      prod <= mul_p;
    end
    if (ctrl.err_en) begin
      err <= signed'(prod[EW-1:0]) - {{(EW - SW){pos[SW-1]}}, pos};
    end
    case (ctrl.acc_op)
      epl_pkg::ACC_LOAD: acc <= prod_x;
      epl_pkg::ACC_ADD:  acc <= acc + prod_x;
      default:           acc <= acc;
    endcase
  end

  // Position wraps, integrator saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      integ <= '0;
    end else begin
      if (ctrl.pos_en) begin
        pos <= pos + SW'(delta);
      end
      if (ctrl.integ_en) begin
        if (isum > epl_pkg::INTEG_MAX) begin
          integ <= epl_pkg::INTEG_MAX[SW-1:0];
        end else if (isum < epl_pkg::INTEG_MIN) begin
          integ <= epl_pkg::INTEG_MIN[SW-1:0];
        end else begin
          integ <= isum[SW-1:0];
        end
      end
    end
  end

  // Magnitude and direction; zero drive reads as reverse
  always_comb begin
    drv_pos = !acc[DW-1] && (acc != '0);
    drv_abs = drv_pos ? acc : -acc;
    rev     = !drv_pos;
    if (|drv_abs[DW-1:8]) begin
      mag = epl_pkg::DRIVE_LIMIT;
    end else begin
      mag = drv_abs[7:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/encoder_pi_position_loop_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_pi_position_loop_unit - microcoded PI position loop
// Reads a setpoint and bit-reversed encoder delta per item, updates the
// wrapping position and saturating integrator and emits a saturated drive
// magnitude with a direction bit.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  input   | in_valid / in_ready       | setpoint_byte, encoder_high_raw, encoder_low_raw
//  output  | out_valid / out_ready     | drive_magnitude, drive_reverse
//  config  | psel/penable/pwrite/pready| paddr[3:2] register, pwdata[7:0] value
//
//  An item passes through one accept step and six microprogram steps that
//  share a single multiplier for target, proportional and integral terms.
//  in_ready is high only in the wait step; the emit step holds while the
//  output register still carries an untaken result.
//  Synchronous reset clears position, integrator, the step counter and the
//  output valid, and restores the gain and scale registers.
//
`default_nettype none

module encoder_pi_position_loop_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  setpoint_byte,
  input  wire logic [7:0]  encoder_high_raw,
  input  wire logic [7:0]  encoder_low_raw,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       drive_magnitude,
  output logic             drive_reverse,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int STW = epl_pkg::STEP_W;

  logic [STW-1:0]       step;
  logic [STW-1:0]       step_next;
  epl_pkg::ctrl_word_t  ctrl;
  logic                 take;
  logic                 out_busy;
  logic                 jump;
  logic                 emit;

  logic [7:0]           setpoint_scale;
  logic [7:0]           gain_proportional;
  logic [7:0]           gain_integral;
  logic [7:0]           dp_mag;
  logic                 dp_rev;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_scale    <= epl_pkg::RESET_SETPOINT_SCALE;
      gain_proportional <= epl_pkg::RESET_GAIN_PROPORTIONAL;
      gain_integral     <= epl_pkg::RESET_GAIN_INTEGRAL;
    end else if (psel && penable && pwrite && pready) begin
      // drop writes beyond the register list
      unique case (paddr[3:2])
        epl_pkg::REG_SETPOINT_SCALE:    setpoint_scale    <= pwdata[7:0];
        epl_pkg::REG_GAIN_PROPORTIONAL: gain_proportional <= pwdata[7:0];
        epl_pkg::REG_GAIN_INTEGRAL:     gain_integral     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      epl_pkg::REG_SETPOINT_SCALE:    prdata = {24'd0, setpoint_scale};
      epl_pkg::REG_GAIN_PROPORTIONAL: prdata = {24'd0, gain_proportional};
      epl_pkg::REG_GAIN_INTEGRAL:     prdata = {24'd0, gain_integral};
      default:                        prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------- sequencer
  // Fetch the control word for the current step from the microcode table
  assign ctrl     = epl_pkg::ucode(step);
  assign in_ready = (step == epl_pkg::ST_WAIT);
  assign take     = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;
  assign emit     = ctrl.out_load && !out_busy;

  always_comb begin
    case (ctrl.jcond)
      epl_pkg::JC_NO_INPUT: jump = !in_valid;
      epl_pkg::JC_OUT_BUSY: jump = out_busy;
      default:              jump = 1'b0;
    endcase
  end

  // Jump when the condition holds, else advance or wrap to the wait step
  always_comb begin
    if (jump) begin
      step_next = ctrl.jtarget;
    end else if (ctrl.last) begin
      step_next = epl_pkg::ST_WAIT;
    end else begin
      step_next = step + STW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= epl_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // --------------------------------------------------------------- datapath
  // Control words stall while the emit step waits, so gate the ones that
  // touch state through the step counter only (emit alone holds)
  epl_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .take              (take),
    .setpoint_byte     (setpoint_byte),
    .encoder_high_raw  (encoder_high_raw),
    .encoder_low_raw   (encoder_low_raw),
    .setpoint_scale    (setpoint_scale),
    .gain_proportional (gain_proportional),
    .gain_integral     (gain_integral),
    .mag               (dp_mag),
    .rev               (dp_rev)
  );

  // ---------------------------------------------------------- output stage
  // Hold the result until taken; load a new one when the register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      drive_magnitude <= dp_mag;
      drive_reverse   <= dp_rev;
    end
  end

endmodule

`default_nettype wire
